### rtl/core/htwc_pkg.sv
// Shared types, constants and the character decoder of the hex text word checksum unit.
package htwc_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharNewline = 8'h0a;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic       is_end;
    logic       is_hex;
    logic       is_nl;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhSkip  = 2'd1,
    PhWord  = 2'd2,
    PhSep   = 2'd3
  } phase_e;

  function automatic token_t classify(input in_item_t item);
    token_t tok;
    tok.is_end = item.cmd;
    tok.is_nl  = (item.ch == CharNewline);
    tok.is_hex = 1'b0;
    tok.digit  = 4'd0;
    if (item.ch inside {[8'h30:8'h39]}) begin
      tok.is_hex = 1'b1;
      tok.digit  = item.ch[3:0];
    end else if (item.ch inside {[8'h61:8'h66]}) begin
      tok.is_hex = 1'b1;
      tok.digit  = item.ch[3:0] + 4'd9;
    end
    return tok;
  endfunction

endpackage

### rtl/core/hex_text_word_checksum_unit.sv
// Top level of the hex text word checksum unit: front decoder, token queue and back parser.
// The unit takes one character per clock cycle while it is not full and sums every group
// of eight lowercase hex digits as a little-endian 32-bit word; a line that starts with
// anything else is skipped. An end item posts the wrapping sum and an error flag, then
// clears the sum. An end item passes through the front register, the token queue (QueueDepth
// entries) and the result register to the output; the back parser finishes one token per
// cycle, and only an end item waits there while an earlier result is not taken.
module hex_text_word_checksum_unit #(
  parameter int unsigned QueueDepth = htwc_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  htwc_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output htwc_pkg::out_item_t out_data_o
);

  logic             front_valid, front_ready;
  htwc_pkg::token_t front_tok;
  logic             queue_valid, queue_pop;
  htwc_pkg::token_t queue_tok;

  htwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready),
    .tok_o       (front_tok)
  );

  htwc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (front_ready),
    .data_i  (front_tok),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .data_o  (queue_tok)
  );

  htwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (queue_valid),
    .tok_pop_o   (queue_pop),
    .tok_i       (queue_tok),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/htwc_front.sv
// Front stage: accepts input items and registers their decoded token.
module htwc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  htwc_pkg::in_item_t in_data_i,
  output logic               tok_valid_o,
  input  logic               tok_ready_i,
  output htwc_pkg::token_t   tok_o
);

  logic             valid_q, valid_d;
  htwc_pkg::token_t tok_q;
  logic             ready;

  assign ready       = !valid_q || tok_ready_i;
  assign full        = !ready;
  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

  always_comb begin
    valid_d = valid_q;
    if (ready) begin
      valid_d = push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && push) begin
      tok_q <= htwc_pkg::classify(in_data_i);
    end
  end

endmodule

### rtl/core/htwc_fifo.sv
// Short token queue between the front and back stages.
module htwc_fifo #(
  parameter int unsigned Depth = htwc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  htwc_pkg::token_t data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output htwc_pkg::token_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  htwc_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("token queue occupancy beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("token queue count did not follow a lone write");

endmodule

### rtl/core/htwc_back.sv
// Back stage: parses tokens into words, keeps the running sum and holds the result.
module htwc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  output logic                tok_pop_o,
  input  htwc_pkg::token_t    tok_i,
  output logic                empty,
  input  logic                pop,
  output htwc_pkg::out_item_t out_data_o
);

  htwc_pkg::phase_e    phase_q, phase_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [31:0]         partial_q, partial_d;
  logic [31:0]         sum_q, sum_d;
  logic                err_q, err_d;
  logic                out_valid_q, out_valid_d;
  htwc_pkg::out_item_t out_q;
  logic                take;
  logic [31:0]         base_word, new_word;
  logic [2:0]          nib_idx;

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;
  assign tok_pop_o  = tok_valid_i && (!tok_i.is_end || !out_valid_q || pop);

  always_comb begin
    nib_idx  = {cnt_q[2:1], ~cnt_q[0]};
    new_word = base_word;
    for (int i = 0; i < 8; i++) begin
      if (nib_idx == 3'(i)) begin
        new_word[i*4 +: 4] = tok_i.digit;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    partial_d   = partial_q;
    sum_d       = sum_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !pop;
    take        = 1'b0;
    base_word   = partial_q;
    if (tok_pop_o) begin
      if (tok_i.is_end) begin
        out_valid_d = 1'b1;
        phase_d     = htwc_pkg::PhStart;
        cnt_d       = '0;
        partial_d   = '0;
        sum_d       = '0;
        err_d       = 1'b0;
      end else begin
        case (phase_q)
          htwc_pkg::PhStart: begin
            if (tok_i.is_hex) begin
              take      = 1'b1;
              base_word = '0;
            end else if (!tok_i.is_nl) begin
              phase_d = htwc_pkg::PhSkip;
            end
          end
          htwc_pkg::PhSkip: begin
            if (tok_i.is_nl) begin
              phase_d = htwc_pkg::PhStart;
            end
          end
          htwc_pkg::PhWord: begin
            if (tok_i.is_hex) begin
              take = 1'b1;
            end else begin
              err_d     = 1'b1;
              partial_d = '0;
              cnt_d     = '0;
              phase_d   = htwc_pkg::PhStart;
            end
          end
          htwc_pkg::PhSep: begin
            phase_d = htwc_pkg::PhStart;
          end
          default: begin
            phase_d = htwc_pkg::PhStart;
          end
        endcase
        if (take) begin
          if (cnt_q == 3'd7) begin
            sum_d     = sum_q + new_word;
            partial_d = '0;
            cnt_d     = '0;
            phase_d   = htwc_pkg::PhSep;
          end else begin
            partial_d = new_word;
            cnt_d     = cnt_q + 3'd1;
            phase_d   = htwc_pkg::PhWord;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= htwc_pkg::PhStart;
      cnt_q       <= '0;
      partial_q   <= '0;
      sum_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      partial_q   <= partial_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o && tok_i.is_end) begin
      out_q.sum    <= sum_q;
      out_q.status <= err_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != htwc_pkg::PhWord) |-> (cnt_q == '0 && partial_q == '0))
    else $error("word assembly state left over outside a word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_pop_o && tok_i.is_end) |=> (sum_q == '0 && !err_q && out_valid_q))
    else $error("end token did not post the result and clear the sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |-> !(tok_pop_o && tok_i.is_end))
    else $error("result overwritten before its transfer");

endmodule
